// File: src/pedal_sensor_plausibility_unit_defines.svh
// Assertion macros used by the pedal sensor plausibility RTL.
`ifndef PEDAL_SENSOR_PLAUSIBILITY_UNIT_DEFINES_SVH
`define PEDAL_SENSOR_PLAUSIBILITY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/psp_pkg.sv
// Types and constants for the pedal sensor plausibility unit.
`default_nettype none

package psp_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIMER_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 24;
    localparam int POS_W      = 7;
    localparam int TORQUE_W   = 10;
    localparam int PRODUCT_W  = GAIN_W + SAMPLE_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_FRAC     = 16;

    localparam logic [POS_W-1:0]   POS_MAX         = 7'd100;
    localparam logic [POS_W-1:0]   AGREE_TOL       = 7'd10;
    localparam logic [TIMER_W-1:0] SHUTDOWN_COUNTS = 16'd10000;

    localparam logic [SAMPLE_W-1:0] S0_LOW_RST    = 12'd200;
    localparam logic [SAMPLE_W-1:0] S0_HIGH_RST   = 12'd2800;
    localparam logic [SAMPLE_W-1:0] S1_LOW_RST    = 12'd400;
    localparam logic [SAMPLE_W-1:0] S1_HIGH_RST   = 12'd3900;
    localparam logic [GAIN_W-1:0]   S0_GAIN_RST   = 16'd3244;
    localparam logic [OFFSET_W-1:0] S0_OFFSET_RST = 24'd1591214;
    localparam logic [GAIN_W-1:0]   S1_GAIN_RST   = 16'd2228;
    localparam logic [OFFSET_W-1:0] S1_OFFSET_RST = 24'd1604977;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_S0_LOW    = 3'd0,
        CFG_S0_HIGH   = 3'd1,
        CFG_S1_LOW    = 3'd2,
        CFG_S1_HIGH   = 3'd3,
        CFG_S0_GAIN   = 3'd4,
        CFG_S0_OFFSET = 3'd5,
        CFG_S1_GAIN   = 3'd6,
        CFG_S1_OFFSET = 3'd7
    } cfg_index_t;

    // Per-sensor calibration seen by one lane.
    typedef struct packed {
        logic [SAMPLE_W-1:0] low_limit;
        logic [SAMPLE_W-1:0] high_limit;
        logic [GAIN_W-1:0]   gain;
        logic [OFFSET_W-1:0] offset;
    } lane_cfg_t;

    // Stage load enables driven by the pipeline control.
    typedef struct packed {
        logic load_mul;
        logic load_pos;
    } lane_ctrl_t;

    typedef struct packed {
        logic             fault;
        logic [POS_W-1:0] position;
    } lane_res_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic [TORQUE_W-1:0] torque_demand;
        logic                command_valid;
        logic                shutdown;
        logic                implausible;
        logic                sensor_fault;
        logic [POS_W-1:0]    position_b;
        logic [POS_W-1:0]    position_a;
    } result_t;

endpackage

`default_nettype wire

// File: src/psp_lane.sv
// One sensor lane: window check, Q16 gain multiply, offset and clamp to percent.
`default_nettype none

module psp_lane (
    input  wire logic                              aclk,
    input  wire psp_pkg::lane_ctrl_t               ctrl,
    input  wire psp_pkg::lane_cfg_t                cfg,
    input  wire logic [psp_pkg::SAMPLE_W-1:0]      sample,
    output psp_pkg::lane_res_t                     res
);

    localparam int DIFF_W  = psp_pkg::PRODUCT_W + 1;
    localparam int WHOLE_W = DIFF_W - psp_pkg::Q_FRAC;

    logic                              fault1_reg;
    logic [psp_pkg::PRODUCT_W-1:0]     prod_reg;
    logic                              fault2_reg;
    logic [psp_pkg::POS_W-1:0]         pos_reg;

    logic                              fault_next;
    logic [psp_pkg::PRODUCT_W-1:0]     prod_next;
    logic signed [DIFF_W-1:0]          diff_s;
    logic [WHOLE_W-1:0]                whole;
    logic [psp_pkg::POS_W-1:0]         pos_next;

    assign fault_next = (sample < cfg.low_limit) || (sample > cfg.high_limit);
    assign prod_next  = {{psp_pkg::SAMPLE_W{1'b0}}, cfg.gain} *
                        {{psp_pkg::GAIN_W{1'b0}}, sample};

    // Exact signed difference; negative clamps to zero.
    assign diff_s = $signed({1'b0, prod_reg}) -
                    $signed({{(DIFF_W - psp_pkg::OFFSET_W){1'b0}}, cfg.offset});
    assign whole  = diff_s[DIFF_W-1:psp_pkg::Q_FRAC];

    always_comb begin
        if (diff_s[DIFF_W-1]) begin
            pos_next = '0;
        end else if (whole > WHOLE_W'(psp_pkg::POS_MAX)) begin
            pos_next = psp_pkg::POS_MAX;
        end else begin
            pos_next = whole[psp_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_mul) begin
            fault1_reg <= fault_next;
            prod_reg   <= prod_next;
        end
        if (ctrl.load_pos) begin
            fault2_reg <= fault1_reg;
            pos_reg    <= pos_next;
        end
    end

    assign res.fault    = fault2_reg;
    assign res.position = pos_reg;

endmodule

`default_nettype wire

// File: src/psp_merge.sv
// Merge stage: agreement check, disagreement timing and the output register.
`default_nettype none

module psp_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire psp_pkg::lane_res_t            lane_a,
    input  wire psp_pkg::lane_res_t            lane_b,
    input  wire logic [psp_pkg::TIMER_W-1:0]   timer_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output psp_pkg::result_t                   out_res
);

    logic                              out_valid_reg;
    logic                              out_valid_next;
    psp_pkg::result_t                  res_reg;
    psp_pkg::result_t                  res_next;
    logic                              flag_reg;
    logic                              flag_next;
    logic [psp_pkg::TIMER_W-1:0]       start_reg;
    logic [psp_pkg::TIMER_W-1:0]       start_next;

    logic                              load;
    logic                              fault;
    logic [psp_pkg::POS_W-1:0]         abs_diff;
    logic                              agree;
    logic [psp_pkg::TIMER_W-1:0]       elapsed;
    logic                              timed_out;
    logic [psp_pkg::TORQUE_W-1:0]      torque;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign fault     = lane_a.fault || lane_b.fault;
    assign abs_diff  = (lane_a.position > lane_b.position) ?
                       (lane_a.position - lane_b.position) :
                       (lane_b.position - lane_a.position);
    assign agree     = abs_diff <= psp_pkg::AGREE_TOL;
    assign elapsed   = timer_count - start_reg;
    assign timed_out = elapsed >= psp_pkg::SHUTDOWN_COUNTS;
    // times ten as 8x + 2x
    assign torque    = {lane_a.position, 3'b000} +
                       {2'b00, lane_a.position, 1'b0};

    always_comb begin
        flag_next  = flag_reg;
        start_next = start_reg;
        res_next   = '0;
        if (fault) begin
            res_next.sensor_fault = 1'b1;
            res_next.implausible  = flag_reg;
        end else begin
            res_next.position_a = lane_a.position;
            res_next.position_b = lane_b.position;
            if (agree) begin
                flag_next              = 1'b0;
                start_next             = '0;
                res_next.command_valid = 1'b1;
                res_next.torque_demand = torque;
            end else begin
                res_next.implausible = 1'b1;
                if (flag_reg) begin
                    res_next.shutdown = timed_out;
                end else begin
                    // first disagreement: start timing
                    flag_next  = 1'b1;
                    start_next = timer_count;
                end
            end
        end
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
            start_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                flag_reg  <= flag_next;
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

`include "pedal_sensor_plausibility_unit_defines.svh"

    `PSP_ASSERT_NOW(a_cmd_clean, aclk, aresetn, out_valid_reg && res_reg.command_valid, !res_reg.implausible && !res_reg.sensor_fault, "command issued with fault or disagreement")
    `PSP_ASSERT_NOW(a_shut_implausible, aclk, aresetn, out_valid_reg && res_reg.shutdown, res_reg.implausible && !res_reg.sensor_fault, "shutdown without an ongoing disagreement")
    `PSP_ASSERT_NOW(a_torque_scale, aclk, aresetn, out_valid_reg && res_reg.command_valid, res_reg.torque_demand == ({3'b000, res_reg.position_a} * 10'd10), "torque is not ten times position")
    `PSP_ASSERT_NOW(a_start_idle, aclk, aresetn, !flag_reg, start_reg == '0, "start time held without disagreement")
    `PSP_ASSERT_NEXT(a_agree_clears, aclk, aresetn, load && !fault && agree, !flag_reg, "agreement did not clear the disagreement state")

endmodule

`default_nettype wire

// File: src/pedal_sensor_plausibility_unit.sv
// Top level of the pedal sensor plausibility unit: registers, lanes and pipeline control.
//
// Takes one sample pair per cycle while the result channel keeps up and returns one
// result item per pair on m_tdata, passing a multiply stage and a position stage in
// each of the two sensor lanes, the second of which feeds the merge stage that compares
// the two positions, times a disagreement against the item's timer count and loads the
// result into the output register. The disagreement state lives in the merge stage
// alone, so consecutive items follow each other without a gap; back-pressure on the
// result channel stalls only the stages that are full. Calibration registers take a
// write in any cycle; change them only while no item is in flight.
`default_nettype none

module pedal_sensor_plausibility_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // sample_a[11:0], sample_b[23:12], timer_count[39:24]
    input  wire logic [39:0]                         s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // position_a[6:0], position_b[13:7], sensor_fault[14], implausible[15],
    // shutdown[16], command_valid[17], torque_demand[27:18], zero fill [31:28]
    output logic [31:0]                              m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_wr_en,
    input  wire logic [psp_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire logic [psp_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int SB_LO = psp_pkg::SAMPLE_W;
    localparam int TM_LO = 2 * psp_pkg::SAMPLE_W;
    localparam int RES_W = $bits(psp_pkg::result_t);

    psp_pkg::lane_cfg_t                cfg_a_reg;
    psp_pkg::lane_cfg_t                cfg_b_reg;

    logic                              v1_reg;
    logic                              v2_reg;
    logic [psp_pkg::TIMER_W-1:0]       timer1_reg;
    logic [psp_pkg::TIMER_W-1:0]       timer2_reg;

    logic                              ready1;
    logic                              ready2;
    logic                              merge_ready;
    psp_pkg::lane_ctrl_t               ctrl;
    psp_pkg::lane_res_t                res_a;
    psp_pkg::lane_res_t                res_b;
    psp_pkg::result_t                  out_res;

    // Calibration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_a_reg.low_limit  <= psp_pkg::S0_LOW_RST;
            cfg_a_reg.high_limit <= psp_pkg::S0_HIGH_RST;
            cfg_a_reg.gain       <= psp_pkg::S0_GAIN_RST;
            cfg_a_reg.offset     <= psp_pkg::S0_OFFSET_RST;
            cfg_b_reg.low_limit  <= psp_pkg::S1_LOW_RST;
            cfg_b_reg.high_limit <= psp_pkg::S1_HIGH_RST;
            cfg_b_reg.gain       <= psp_pkg::S1_GAIN_RST;
            cfg_b_reg.offset     <= psp_pkg::S1_OFFSET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                psp_pkg::CFG_S0_LOW:    cfg_a_reg.low_limit  <= cfg_wr_data[psp_pkg::SAMPLE_W-1:0];
                psp_pkg::CFG_S0_HIGH:   cfg_a_reg.high_limit <= cfg_wr_data[psp_pkg::SAMPLE_W-1:0];
                psp_pkg::CFG_S1_LOW:    cfg_b_reg.low_limit  <= cfg_wr_data[psp_pkg::SAMPLE_W-1:0];
                psp_pkg::CFG_S1_HIGH:   cfg_b_reg.high_limit <= cfg_wr_data[psp_pkg::SAMPLE_W-1:0];
                psp_pkg::CFG_S0_GAIN:   cfg_a_reg.gain       <= cfg_wr_data[psp_pkg::GAIN_W-1:0];
                psp_pkg::CFG_S0_OFFSET: cfg_a_reg.offset     <= cfg_wr_data[psp_pkg::OFFSET_W-1:0];
                psp_pkg::CFG_S1_GAIN:   cfg_b_reg.gain       <= cfg_wr_data[psp_pkg::GAIN_W-1:0];
                psp_pkg::CFG_S1_OFFSET: cfg_b_reg.offset     <= cfg_wr_data[psp_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign ready2        = !v2_reg || merge_ready;
    assign ready1        = !v1_reg || ready2;
    assign s_tready      = ready1;
    assign ctrl.load_mul = s_tvalid && ready1;
    assign ctrl.load_pos = v1_reg && ready2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Carry the timer count alongside the item.
    always_ff @(posedge aclk) begin
        if (ctrl.load_mul) begin
            timer1_reg <= s_tdata[TM_LO +: psp_pkg::TIMER_W];
        end
        if (ctrl.load_pos) begin
            timer2_reg <= timer1_reg;
        end
    end

    psp_lane u_lane_a (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .cfg    (cfg_a_reg),
        .sample (s_tdata[0 +: psp_pkg::SAMPLE_W]),
        .res    (res_a)
    );

    psp_lane u_lane_b (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .cfg    (cfg_b_reg),
        .sample (s_tdata[SB_LO +: psp_pkg::SAMPLE_W]),
        .res    (res_b)
    );

    psp_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v2_reg),
        .in_ready    (merge_ready),
        .lane_a      (res_a),
        .lane_b      (res_b),
        .timer_count (timer2_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res)
    );

    assign m_tdata = {{(32 - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire
